// ===== hw/rtl/tls_pkg.sv =====
// Shared constants, side codes and root-table helpers for the translucent lobe shader.
// No dependencies; every other file in hw/rtl imports this package.
package tls_pkg;

  // Default fraction bits of the direction vectors (Q2.14)
  localparam int VEC_FRAC_BITS_DEF = 14;

  // Unit vectors carry a sign, one integer bit and 16 fraction bits
  localparam int UNIT_W = 18;

  // Pipelined divider and square-root step counts inside the normalizer
  localparam int DIV_STEPS  = 33;
  localparam int SQRT_STEPS = 17;
  localparam int NORM_LAT   = 5 + DIV_STEPS + SQRT_STEPS + 1;

  // Power unit: classify, 16 log steps, two scale stages, 16 exp steps, output
  localparam int POW_STEPS = 16;
  localparam int POW_LAT   = 1 + POW_STEPS + 2 + POW_STEPS + 1;

  // 1/pi in Q0.32
  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

  // Grazing threshold after reset
  localparam logic [9:0] THRESH_RESET = 10'd1;

  typedef enum logic [1:0] {
    SIDE_TRANS = 2'd0,
    SIDE_FRONT = 2'd1,
    SIDE_BACK  = 2'd2,
    SIDE_GRAZE = 2'd3
  } side_t;

  // Floor square root, evaluated at elaboration for the root table
  function automatic logic [63:0] isqrt_c(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xr;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    xr = x;
    for (int j = 0; j < 32; j++) begin
      if (xr >= r + b) begin
        xr = xr - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q1.30 value of 2^-(2^-idx): first sqrt(1/2), then repeated roots
  function automatic logic [63:0] root_coef(int idx);
    logic [63:0] c;
    c = isqrt_c(64'd1 << 59);
    for (int j = 1; j < 17; j++) begin
      if (j < idx) begin
        c = isqrt_c(c << 30);
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/translucent_lobe_shade_core.sv =====
// Top level of the translucent lobe shader: direction setup, side select, lobe power, color scale.
// Depends on tls_pkg, tls_norm and tls_pow.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------------
//  input    | start / busy     | light_*, view_dir_*, normal_*, lobe_exponent, colors
//  result   | done (one cycle) | shade_value, side_code
//  config   | cfg_we           | cfg_data (near-zero threshold)
//
// One beat is accepted every clock; busy stays low. On its way to the result an input beat
// passes two vector normalizers of 56 stages each (33 divide and 17 square-root steps)
// and the 36-stage power unit. Reset clears the valid bits and sets the threshold to 1. The
// receiver cannot stall, so the pipeline never holds.
module translucent_lobe_shade_core #(
  parameter int VEC_FRAC_BITS = tls_pkg::VEC_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  input  logic [15:0] light_x,
  input  logic [15:0] light_y,
  input  logic [15:0] light_z,
  input  logic [15:0] view_dir_x,
  input  logic [15:0] view_dir_y,
  input  logic [15:0] view_dir_z,
  input  logic [15:0] normal_x,
  input  logic [15:0] normal_y,
  input  logic [15:0] normal_z,
  input  logic [15:0] lobe_exponent,
  input  logic [15:0] transmit_color,
  input  logic [15:0] reflect_color,
  output logic [15:0] shade_value,
  output logic [1:0]  side_code
);
  import tls_pkg::*;

  // Widths along the reflection path
  localparam int F      = VEC_FRAC_BITS;
  localparam int A_W    = 33 - F;
  localparam int PM_W   = A_W + 16;
  localparam int SC_RAW = PM_W - (F - 1);
  localparam int SC_W   = (SC_RAW > 1) ? SC_RAW : 1;
  localparam int W_W    = ((SC_W + 1 > UNIT_W) ? SC_W + 1 : UNIT_W) + 1;

  typedef struct packed {
    logic [2:0][15:0] n;
    logic [15:0]      expo;
    logic [15:0]      tcol;
    logic [15:0]      rcol;
  } pa_t;

  typedef struct packed {
    logic [2:0][UNIT_W-1:0] v;
    logic [2:0][UNIT_W-1:0] r;
    logic [2:0][15:0]       n;
    logic [15:0]            expo;
    logic [15:0]            tcol;
    logic [15:0]            rcol;
  } dc_t;

  typedef struct packed {
    logic [2:0][UNIT_W-1:0] v;
    side_t                  side;
    logic [15:0]            expo;
    logic [15:0]            tcol;
    logic [15:0]            rcol;
  } pb_t;

  typedef struct packed {
    side_t       side;
    logic [15:0] tcol;
    logic [15:0] rcol;
  } pc_t;

  logic [9:0] thresh;

  // Entry stage
  logic                s0_vld;
  logic signed [16:0]  s0_l [3];
  logic signed [16:0]  s0_d [3];
  pa_t                 s0_p;
  pa_t                 pa [NORM_LAT];

  logic                        vn_valid;
  logic signed [UNIT_W-1:0]    v_u [3];
  logic signed [UNIT_W-1:0]    r_u [3];

  // Dot product and reflection stages
  logic                d1_vld, d2_vld, d3_vld, d4_vld, d5_vld;
  dc_t                 d1_c, d2_c, d3_c, d4_c;
  logic signed [33:0]  d1_nr [3];
  logic signed [33:0]  d1_nv [3];
  logic signed [35:0]  d2_nr, d2_nv;
  logic [35:0]         nr_mag;
  logic signed [35:0]  th;
  side_t               side_sel;
  logic [A_W-1:0]      d3_a;
  side_t               d3_side, d4_side;
  logic [PM_W-1:0]     d4_pm [3];
  logic [2:0]          d4_neg;
  logic [SC_W-1:0]     sc [3];
  logic signed [W_W-1:0] rx [3];
  logic signed [W_W-1:0] scx [3];
  logic signed [W_W-1:0] d5_w [3];
  pb_t                 d5_c;
  pb_t                 pb [NORM_LAT];

  logic                        wn_valid;
  logic signed [UNIT_W-1:0]    wu [3];

  // Cosine stages
  logic                e1_vld, e2_vld, e3_vld;
  logic signed [35:0]  e1_p [3];
  logic signed [37:0]  e2_dot;
  logic [37:0]         dot_mag;
  logic [21:0]         dot_sh;
  logic [16:0]         e3_sd;
  pb_t                 e1_c, e2_c, e3_c;
  pc_t                 pc [POW_LAT];

  logic        pw_valid;
  logic [16:0] inten;

  // Color scale stages
  logic        f1_vld, f2_vld;
  logic [32:0] f1_ci;
  logic [63:0] f2_x;
  side_t       f1_side, f2_side;

  assign busy = 1'b0;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh <= cfg_data;
    end
  end

  // Valid bits of the local stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      d1_vld <= 1'b0;
      d2_vld <= 1'b0;
      d3_vld <= 1'b0;
      d4_vld <= 1'b0;
      d5_vld <= 1'b0;
      e1_vld <= 1'b0;
      e2_vld <= 1'b0;
      e3_vld <= 1'b0;
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      s0_vld <= start & ~busy;
      d1_vld <= vn_valid;
      d2_vld <= d1_vld;
      d3_vld <= d2_vld;
      d4_vld <= d3_vld;
      d5_vld <= d4_vld;
      e1_vld <= wn_valid;
      e2_vld <= e1_vld;
      e3_vld <= e2_vld;
      f1_vld <= pw_valid;
      f2_vld <= f1_vld;
      done   <= f2_vld;
    end
  end

  // Capture the input beat; the view ray is negated
  always_ff @(posedge clk) begin
    s0_l[0] <= 17'($signed(light_x));
    s0_l[1] <= 17'($signed(light_y));
    s0_l[2] <= 17'($signed(light_z));
    s0_d[0] <= -17'($signed(view_dir_x));
    s0_d[1] <= -17'($signed(view_dir_y));
    s0_d[2] <= -17'($signed(view_dir_z));
    s0_p.n    <= {normal_z, normal_y, normal_x};
    s0_p.expo <= lobe_exponent;
    s0_p.tcol <= transmit_color;
    s0_p.rcol <= reflect_color;
  end

  // Hold the side data beside the first normalizers
  always_ff @(posedge clk) begin
    pa[0] <= s0_p;
    for (int i = 1; i < NORM_LAT; i++) pa[i] <= pa[i-1];
  end

  tls_norm #(.IN_W(17)) u_norm_light (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_vld),
    .in_vec    (s0_l),
    .out_valid (vn_valid),
    .out_vec   (v_u)
  );

  tls_norm #(.IN_W(17)) u_norm_view (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_vld),
    .in_vec    (s0_d),
    .out_valid (),
    .out_vec   (r_u)
  );

  // Dot product terms
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d1_nr[k]  <= 34'($signed(pa[NORM_LAT-1].n[k])) * 34'(r_u[k]);
      d1_nv[k]  <= 34'($signed(pa[NORM_LAT-1].n[k])) * 34'(v_u[k]);
      d1_c.v[k] <= v_u[k];
      d1_c.r[k] <= r_u[k];
    end
    d1_c.n    <= pa[NORM_LAT-1].n;
    d1_c.expo <= pa[NORM_LAT-1].expo;
    d1_c.tcol <= pa[NORM_LAT-1].tcol;
    d1_c.rcol <= pa[NORM_LAT-1].rcol;
  end

  // Dot product sums
  always_ff @(posedge clk) begin
    d2_nr <= 36'(d1_nr[0]) + 36'(d1_nr[1]) + 36'(d1_nr[2]);
    d2_nv <= 36'(d1_nv[0]) + 36'(d1_nv[1]) + 36'(d1_nv[2]);
    d2_c  <= d1_c;
  end

  // Side select against the grazing band
  assign th     = $signed({10'b0, thresh, 16'b0});
  assign nr_mag = d2_nr[35] ? 36'(-d2_nr) : 36'(d2_nr);

  always_comb begin
    priority if (d2_nr <= 36'sd0) begin
      side_sel = (d2_nv <= -th) ? SIDE_FRONT : SIDE_TRANS;
    end else if (d2_nr >= th) begin
      side_sel = (d2_nv >= th) ? SIDE_BACK : SIDE_TRANS;
    end else begin
      side_sel = SIDE_GRAZE;
    end
  end

  always_ff @(posedge clk) begin
    d3_a    <= A_W'(nr_mag >> F);
    d3_side <= side_sel;
    d3_c    <= d2_c;
  end

  // Scale the normal by |n.r|
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d4_pm[k]  <= PM_W'(d3_a) *
                   PM_W'(d3_c.n[k][15] ? 16'(-d3_c.n[k]) : d3_c.n[k]);
      d4_neg[k] <= d3_c.n[k][15];
    end
    d4_side <= d3_side;
    d4_c    <= d3_c;
  end

  // Mirror the view vector about the normal
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sc[k]  = SC_W'(d4_pm[k] >> (F - 1));
      rx[k]  = W_W'($signed(d4_c.r[k]));
      scx[k] = W_W'(sc[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d5_w[k] <= d4_neg[k] ? rx[k] + scx[k] : rx[k] - scx[k];
    end
    d5_c.v    <= d4_c.v;
    d5_c.side <= d4_side;
    d5_c.expo <= d4_c.expo;
    d5_c.tcol <= d4_c.tcol;
    d5_c.rcol <= d4_c.rcol;
  end

  // Hold the side data beside the reflection normalizer
  always_ff @(posedge clk) begin
    pb[0] <= d5_c;
    for (int i = 1; i < NORM_LAT; i++) pb[i] <= pb[i-1];
  end

  tls_norm #(.IN_W(W_W)) u_norm_refl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d5_vld),
    .in_vec    (d5_w),
    .out_valid (wn_valid),
    .out_vec   (wu)
  );

  // Cosine of the lobe angle
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_p[k] <= 36'(wu[k]) * 36'($signed(pb[NORM_LAT-1].v[k]));
    end
    e1_c <= pb[NORM_LAT-1];
  end

  always_ff @(posedge clk) begin
    e2_dot <= 38'(e1_p[0]) + 38'(e1_p[1]) + 38'(e1_p[2]);
    e2_c   <= e1_c;
  end

  assign dot_mag = e2_dot[37] ? 38'(-e2_dot) : 38'(e2_dot);
  assign dot_sh  = dot_mag[37:16];

  always_ff @(posedge clk) begin
    e3_sd <= (dot_sh > 22'd65536) ? 17'h10000 : dot_sh[16:0];
    e3_c  <= e2_c;
  end

  // Hold the colors beside the power unit
  always_ff @(posedge clk) begin
    pc[0].side <= e3_c.side;
    pc[0].tcol <= e3_c.tcol;
    pc[0].rcol <= e3_c.rcol;
    for (int i = 1; i < POW_LAT; i++) pc[i] <= pc[i-1];
  end

  tls_pow u_pow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e3_vld),
    .sd        (e3_sd),
    .expo      (e3_c.expo),
    .out_valid (pw_valid),
    .inten     (inten)
  );

  // Color times intensity, then times 1/pi
  always_ff @(posedge clk) begin
    f1_ci   <= 33'(pc[POW_LAT-1].side == SIDE_TRANS ? pc[POW_LAT-1].tcol
                                                    : pc[POW_LAT-1].rcol) * 33'(inten);
    f1_side <= pc[POW_LAT-1].side;
    f2_x    <= 64'(f1_ci) * 64'(INV_PI_Q32);
    f2_side <= f1_side;
  end

  // Drive the result beat; grazing gives zero
  always_ff @(posedge clk) begin
    shade_value <= (f2_side == SIDE_GRAZE) ? 16'd0 : f2_x[63:48];
    side_code   <= f2_side;
  end

endmodule

// ===== hw/rtl/tls_norm.sv =====
// Pipelined 3-vector normalizer: range shift, squares, restoring divide, digit sqrt.
// Depends on tls_pkg for step counts and the unit vector width.
module tls_norm #(
  parameter int IN_W = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [IN_W-1:0]              in_vec [3],
  output logic                                out_valid,
  output logic signed [tls_pkg::UNIT_W-1:0]   out_vec [3]
);
  import tls_pkg::*;

  // IN_W is 17 or more: the magnitude may exceed the 32768 limit
  localparam int SH_MAX = IN_W - 16;
  localparam int SH_W   = $clog2(SH_MAX + 2);
  localparam int LAT    = NORM_LAT;
  localparam logic [IN_W-1:0] MAG_LIM = IN_W'(32768);

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } nflag_t;

  logic           vld   [LAT];
  nflag_t         flg   [LAT];
  nflag_t         flg_in;

  logic [IN_W-1:0] mag1 [3];
  logic [IN_W-1:0] mag2 [3];
  logic [SH_W-1:0] sh_sel;
  logic [SH_W-1:0] sh2;
  logic [15:0]     m3   [3];
  logic [31:0]     sq4  [3];
  logic [31:0]     sq5  [3];
  logic [31:0]     l5;

  logic [32:0] dr [DIV_STEPS][3];
  logic [32:0] dq [DIV_STEPS][3];
  logic [31:0] dl [DIV_STEPS];

  logic [32:0] sx [SQRT_STEPS][3];
  logic [33:0] sr [SQRT_STEPS][3];

  // Capture sign and all-zero flags at entry
  always_comb begin
    flg_in.zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
    for (int k = 0; k < 3; k++) begin
      flg_in.neg[k] = in_vec[k][IN_W-1];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Advance flags
  always_ff @(posedge clk) begin
    flg[0] <= flg_in;
    for (int i = 1; i < LAT; i++) flg[i] <= flg[i-1];
  end

  // Pick the smallest shift that brings every magnitude to 32768 or below
  always_comb begin
    sh_sel = SH_W'(SH_MAX);
    for (int s = SH_MAX; s >= 0; s--) begin
      if (((mag1[0] >> s) <= MAG_LIM) && ((mag1[1] >> s) <= MAG_LIM) &&
          ((mag1[2] >> s) <= MAG_LIM)) begin
        sh_sel = SH_W'(s);
      end
    end
  end

  // Magnitudes, shift, squares, length
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag1[k] <= in_vec[k][IN_W-1] ? IN_W'(-in_vec[k]) : IN_W'(in_vec[k]);
      mag2[k] <= mag1[k];
      m3[k]   <= 16'(mag2[k] >> sh2);
      sq4[k]  <= 32'(m3[k]) * 32'(m3[k]);
      sq5[k]  <= sq4[k];
    end
    sh2 <= sh_sel;
    l5  <= 32'(34'(sq4[0]) + 34'(sq4[1]) + 34'(sq4[2]));
  end

  // Restoring divide: one quotient bit of (sq << 32) / len per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [32:0] rin [3];
    logic [32:0] qin [3];
    logic [31:0] lin;
    if (j == 0) begin : g_first
      always_comb begin
        lin = l5;
        for (int k = 0; k < 3; k++) begin
          rin[k] = {1'b0, sq5[k]};
          qin[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        lin = dl[j-1];
        for (int k = 0; k < 3; k++) begin
          rin[k] = {dr[j-1][k][31:0], 1'b0};
          qin[k] = dq[j-1][k];
        end
      end
    end
    always_ff @(posedge clk) begin
      dl[j] <= lin;
      for (int k = 0; k < 3; k++) begin
        if (rin[k] >= {1'b0, lin}) begin
          dr[j][k] <= rin[k] - {1'b0, lin};
          dq[j][k] <= {qin[k][31:0], 1'b1};
        end else begin
          dr[j][k] <= rin[k];
          dq[j][k] <= {qin[k][31:0], 1'b0};
        end
      end
    end
  end

  // Digit-by-digit square root, one root bit per stage
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [33:0] ONE_AT = 34'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [32:0] xin  [3];
    logic [33:0] rtin [3];
    logic [33:0] cand [3];
    if (i == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          xin[k]  = dq[DIV_STEPS-1][k];
          rtin[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          xin[k]  = sx[i-1][k];
          rtin[k] = sr[i-1][k];
        end
      end
    end
    always_comb begin
      for (int k = 0; k < 3; k++) cand[k] = rtin[k] + ONE_AT;
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if ({1'b0, xin[k]} >= cand[k]) begin
          sx[i][k] <= 33'({1'b0, xin[k]} - cand[k]);
          sr[i][k] <= (rtin[k] >> 1) + ONE_AT;
        end else begin
          sx[i][k] <= xin[k];
          sr[i][k] <= rtin[k] >> 1;
        end
      end
    end
  end

  // Apply sign; a zero-length vector stays zero
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (flg[LAT-2].zero) begin
        out_vec[k] <= '0;
      end else if (flg[LAT-2].neg[k]) begin
        out_vec[k] <= -$signed({1'b0, sr[SQRT_STEPS-1][k][16:0]});
      end else begin
        out_vec[k] <= $signed({1'b0, sr[SQRT_STEPS-1][k][16:0]});
      end
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

// ===== hw/rtl/tls_pow.sv =====
// Pipelined power unit: sd^e in Q16 through a squaring log2 and a root-product exp2.
// Depends on tls_pkg for the stage counts and the root coefficients.
module tls_pow (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [16:0] sd,
  input  logic [15:0] expo,
  output logic        out_valid,
  output logic [16:0] inten
);
  import tls_pkg::*;

  localparam int LAT = POW_LAT;

  typedef struct packed {
    logic spec;
    logic one;
  } pspec_t;

  logic   vld [LAT];
  pspec_t spc [LAT];
  pspec_t spc_in;

  logic [3:0]  p_sel;
  logic [30:0] m1;
  logic [3:0]  p1;
  logic [15:0] e1;

  logic [30:0] lm [POW_STEPS];
  logic [15:0] lf [POW_STEPS];
  logic [3:0]  lp [POW_STEPS];
  logic [15:0] le [POW_STEPS];

  logic [20:0] nl;
  logic [15:0] e_n;
  logic [36:0] t_full;
  logic [15:0] fr;
  logic [4:0]  k5;
  logic        over;

  logic [30:0] xp  [POW_STEPS];
  logic [15:0] xfr [POW_STEPS];
  logic [4:0]  xk  [POW_STEPS];
  logic        xov [POW_STEPS];

  // Classify the trivial cases
  always_comb begin
    spc_in.spec = 1'b0;
    spc_in.one  = 1'b0;
    priority if (expo == '0) begin
      spc_in.spec = 1'b1;
      spc_in.one  = 1'b1;
    end else if (sd == '0) begin
      spc_in.spec = 1'b1;
    end else if (sd[16]) begin
      spc_in.spec = 1'b1;
      spc_in.one  = 1'b1;
    end else begin
      spc_in.spec = 1'b0;
    end
  end

  // Leading one of sd
  always_comb begin
    p_sel = '0;
    for (int b = 0; b < 16; b++) begin
      if (sd[b]) p_sel = 4'(b);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Advance special-case flags; normalize the mantissa to Q1.30
  always_ff @(posedge clk) begin
    spc[0] <= spc_in;
    for (int i = 1; i < LAT; i++) spc[i] <= spc[i-1];
    m1 <= 31'(sd[15:0]) << (5'd30 - {1'b0, p_sel});
    p1 <= p_sel;
    e1 <= expo;
  end

  // Log2 fraction: square the mantissa, one result bit per stage
  for (genvar i = 0; i < POW_STEPS; i++) begin : g_log
    logic [30:0] min;
    logic [15:0] fin;
    logic [3:0]  pin;
    logic [15:0] ein;
    logic [61:0] sq;
    if (i == 0) begin : g_first
      assign min = m1;
      assign fin = '0;
      assign pin = p1;
      assign ein = e1;
    end else begin : g_next
      assign min = lm[i-1];
      assign fin = lf[i-1];
      assign pin = lp[i-1];
      assign ein = le[i-1];
    end
    assign sq = 62'(min) * 62'(min);
    always_ff @(posedge clk) begin
      lm[i] <= sq[61] ? sq[61:31] : sq[60:30];
      lf[i] <= {fin[14:0], sq[61]};
      lp[i] <= pin;
      le[i] <= ein;
    end
  end

  // Scale -log2 by the exponent and split into integer and fraction
  assign t_full = 37'(nl) * 37'(e_n);

  always_ff @(posedge clk) begin
    nl   <= (21'(5'd16 - {1'b0, lp[POW_STEPS-1]}) << 16) - 21'(lf[POW_STEPS-1]);
    e_n  <= le[POW_STEPS-1];
    fr   <= t_full[23:8];
    k5   <= t_full[28:24];
    over <= (t_full[36:24] > 13'd16);
  end

  // Exp2 of the fraction: one root factor per set bit
  for (genvar i = 0; i < POW_STEPS; i++) begin : g_exp
    localparam logic [63:0] COEF_FULL = root_coef(i + 1);
    localparam logic [30:0] COEF      = COEF_FULL[30:0];
    logic [30:0] pin;
    logic [15:0] frin;
    logic [4:0]  kin;
    logic        ovin;
    logic [61:0] pp;
    if (i == 0) begin : g_first
      assign pin  = 31'(1) << 30;
      assign frin = fr;
      assign kin  = k5;
      assign ovin = over;
    end else begin : g_next
      assign pin  = xp[i-1];
      assign frin = xfr[i-1];
      assign kin  = xk[i-1];
      assign ovin = xov[i-1];
    end
    assign pp = 62'(pin) * 62'(COEF);
    always_ff @(posedge clk) begin
      xp[i]  <= frin[POW_STEPS-1-i] ? pp[60:30] : pin;
      xfr[i] <= frin;
      xk[i]  <= kin;
      xov[i] <= ovin;
    end
  end

  // Apply the integer part and the special cases
  always_ff @(posedge clk) begin
    priority if (spc[LAT-2].spec) begin
      inten <= spc[LAT-2].one ? 17'h10000 : '0;
    end else if (xov[POW_STEPS-1]) begin
      inten <= '0;
    end else begin
      inten <= xp[POW_STEPS-1][30:14] >> xk[POW_STEPS-1];
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for translucent_lobe_shade_core: directed and random shading samples.
// Depends on tls_pkg and the core RTL; results are checked against an in-bench bit-exact predictor.
`timescale 1ns / 1ps

module tb;
  import tls_pkg::*;

  localparam int FRAC     = 14;
  localparam int LATENCY  = 160;
  localparam longint unsigned RECIP_PI = 64'd1367130551;

  typedef struct packed {
    logic [15:0] lx, ly, lz;
    logic [15:0] dx, dy, dz;
    logic [15:0] nx, ny, nz;
    logic [15:0] expo;
    logic [15:0] tcol, rcol;
  } sample_t;

  typedef struct packed {
    logic [15:0] shade;
    side_t       side;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic cfg_we = 1'b0;
  logic [9:0] cfg_data = '0;
  logic [15:0] shade_value;
  logic [1:0] side_code;
  sample_t cur = '0;

  sample_t sample_q[$];
  shade_t  shade_q[$];
  logic [9:0] thresh_now = THRESH_RESET;
  int gap = 0;
  int no_idle = 0;
  int err_count = 0;
  int beats_in = 0;
  int beats_out = 0;
  int side_hits[4] = '{0, 0, 0, 0};

  translucent_lobe_shade_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .light_x(cur.lx), .light_y(cur.ly), .light_z(cur.lz),
    .view_dir_x(cur.dx), .view_dir_y(cur.dy), .view_dir_z(cur.dz),
    .normal_x(cur.nx), .normal_y(cur.ny), .normal_z(cur.nz),
    .lobe_exponent(cur.expo), .transmit_color(cur.tcol), .reflect_color(cur.rcol),
    .shade_value(shade_value), .side_code(side_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale a vector to 16 fraction bits, keeping component signs
  function automatic void to_unit(input longint iv[3], output longint ov[3]);
    longint unsigned m[3];
    longint unsigned mx, len;
    int s;
    mx = 0;
    len = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m[k] = mag(iv[k]);
      if (m[k] > mx) mx = m[k];
    end
    while ((mx >> s) > 32768) s++;
    for (int k = 0; k < 3; k++) begin
      m[k] = m[k] >> s;
      len += m[k] * m[k];
    end
    for (int k = 0; k < 3; k++) begin
      longint u;
      u = 0;
      if (len != 0) u = longint'(floor_sqrt(((m[k] * m[k]) << 32) / len));
      ov[k] = iv[k] < 0 ? -u : u;
    end
  endfunction

  // sd^e in Q.16 via log2 and root products
  function automatic longint unsigned lobe_power(longint unsigned sd, longint unsigned e);
    longint unsigned m, f, nl, t, k, fr, c, prod;
    int p;
    f = 0;
    p = 0;
    if (e == 0) return 65536;
    if (sd == 0) return 0;
    if (sd >= 65536) return 65536;
    while ((sd >> (p + 1)) != 0) p++;
    m = sd << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        f = f | 1;
        m = m >> 1;
      end
    end
    nl = (longint'(16 - p) << 16) - f;
    t = (nl * e) >> 8;
    k = t >> 16;
    fr = t & 16'hFFFF;
    if (k > 16) return 0;
    c = floor_sqrt(64'd1 << 59);
    prod = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if ((fr >> (16 - i)) & 1) prod = (prod * c) >> 30;
      c = floor_sqrt(c << 30);
    end
    return (prod >> 14) >> k;
  endfunction

  function automatic shade_t predict_shade(sample_t s, logic [9:0] thr);
    longint l[3], d[3], n[3], v[3], r[3], w[3], wu[3];
    longint nr, nv, th;
    longint unsigned a, sd, inten, color, sh;
    shade_t res;
    l = '{longint'($signed(s.lx)), longint'($signed(s.ly)), longint'($signed(s.lz))};
    d = '{-longint'($signed(s.dx)), -longint'($signed(s.dy)), -longint'($signed(s.dz))};
    n = '{longint'($signed(s.nx)), longint'($signed(s.ny)), longint'($signed(s.nz))};
    to_unit(l, v);
    to_unit(d, r);
    nr = n[0] * r[0] + n[1] * r[1] + n[2] * r[2];
    nv = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
    th = longint'(thr) << 16;
    a = mag(nr) >> FRAC;
    for (int k = 0; k < 3; k++) begin
      longint pr, sc;
      pr = 2 * longint'(a) * n[k];
      sc = longint'(mag(pr) >> FRAC);
      w[k] = r[k] - (pr < 0 ? -sc : sc);
    end
    to_unit(w, wu);
    sd = mag(wu[0] * v[0] + wu[1] * v[1] + wu[2] * v[2]) >> 16;
    if (sd > 65536) sd = 65536;
    inten = lobe_power(sd, s.expo);
    if (nr <= 0) res.side = (nv <= -th) ? SIDE_FRONT : SIDE_TRANS;
    else if (nr >= th) res.side = (nv >= th) ? SIDE_BACK : SIDE_TRANS;
    else res.side = SIDE_GRAZE;
    if (res.side == SIDE_GRAZE) begin
      sh = 0;
    end else begin
      color = (res.side == SIDE_TRANS) ? s.tcol : s.rcol;
      sh = (color * inten * RECIP_PI) >> 48;
      if (sh > 65535) sh = 65535;
    end
    res.shade = sh[15:0];
    return res;
  endfunction

  // ---------------- driver ----------------
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle != 0 || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one beat per accepted item, with random idle gaps in between
  always @(posedge clk) begin : drive
    logic took;
    if (rst) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        shade_q.push_back(predict_shade(cur, thresh_now));
        beats_in++;
      end
      if (start && !took) begin
        // hold the beat until it is taken
      end else if (gap != 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (sample_q.size() > 0) begin
        cur <= sample_q.pop_front();
        start <= 1'b1;
        gap <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : watch
    shade_t want;
    if (!rst && done) begin
      beats_out++;
      side_hits[side_code]++;
      if (shade_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = shade_q.pop_front();
        if (shade_value !== want.shade) report_mismatch("shade_value", shade_value, want.shade);
        if (side_code !== want.side) report_mismatch("side_code", side_code, want.side);
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic sample_t mk(int lx, int ly, int lz, int dx, int dy, int dz,
                                 int nx, int ny, int nz, int e, int tc, int rc);
    sample_t s;
    s = '{lx[15:0], ly[15:0], lz[15:0], dx[15:0], dy[15:0], dz[15:0],
          nx[15:0], ny[15:0], nz[15:0], e[15:0], tc[15:0], rc[15:0]};
    return s;
  endfunction

  // Random direction scaled to the given length in Q2.14
  function automatic void rand_dir(input real len, output int c[3]);
    real x, y, z, m;
    x = $itor($urandom_range(0, 2000)) - 1000.0;
    y = $itor($urandom_range(0, 2000)) - 1000.0;
    z = $itor($urandom_range(0, 2000)) - 1000.0;
    m = $sqrt(x * x + y * y + z * z);
    if (m < 1.0) begin
      x = 1.0;
      m = 1.0;
    end
    c[0] = $rtoi(x / m * len);
    c[1] = $rtoi(y / m * len);
    c[2] = $rtoi(z / m * len);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int l[3], d[3], n[3];
    int e;
    s = sample_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 99) < 80) begin
      // Well-formed sample: unit normal, mostly moderate lobe exponent
      rand_dir($itor($urandom_range(200, 32767)), l);
      rand_dir($itor($urandom_range(200, 32767)), d);
      rand_dir(16384.0, n);
      e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 16'h2000);
      s = mk(l[0], l[1], l[2], d[0], d[1], d[2], n[0], n[1], n[2], e,
             $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
    return s;
  endfunction

  task automatic wait_idle();
    while (sample_q.size() != 0 || start || shade_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_thresh(logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh_now = val;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) sample_q.push_back(rand_sample());
  endtask

  initial begin : stim
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, transmit, front and back sides, zero vectors, flat and steep lobes
    sample_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    sample_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, 65535, 65535, 65535));
    sample_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, 65535, 65535, 65535));
    sample_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 256, 65535, 65535));
    sample_q.push_back(mk(0, 0, 0, 0, 0, -16384, 0, 0, 16384, 256, 40000, 50000));
    sample_q.push_back(mk(0, 0, 16384, 0, 0, 0, 0, 0, 16384, 256, 40000, 50000));
    sample_q.push_back(mk(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 0, 65535, 65535));
    sample_q.push_back(mk(0, 0, -16384, 0, 0, 16384, 0, 0, 16384, 256, 65535, 30000));
    sample_q.push_back(mk(0, 0, 16384, 0, 0, -16384, 0, 0, 16384, 512, 30000, 65535));
    sample_q.push_back(mk(0, 0, -16384, 0, 0, -16384, 0, 0, 16384, 256, 20000, 60000));
    sample_q.push_back(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 256, 65535, 65535));
    sample_q.push_back(mk(0, 0, 16384, 16384, 0, 1, 0, 0, 16384, 256, 65535, 65535));
    sample_q.push_back(mk(5000, 3000, 16000, -2000, 1000, -16000, 0, 0, 16384,
                          65535, 65535, 65535));
    sample_q.push_back(mk(5000, 3000, 16000, -2000, 1000, -16000, 0, 0, 16384,
                          1, 65535, 65535));
    sample_q.push_back(mk(9000, 3000, 12000, -7000, 4000, -12000, 0, 0, 16384,
                          16'h0180, 65535, 65535));
    sample_q.push_back(mk(100, -20000, 300, 7, -9, 32767, 32767, 0, 32767,
                          16'h0800, 1, 65535));
    sample_q.push_back(mk(0, 0, 16384, 0, 0, -16384, 0, 0, 11585, 256, 65535, 65535));
    sample_q.push_back(mk(0, 0, 16384, 0, 0, -16384, 0, 0, 8192, 256, 65535, 65535));
    sample_q.push_back(mk(1, 0, 0, 0, 1, 0, 1, 1, 0, 256, 12345, 54321));
    wait_idle();

    // Random phases across threshold settings, reset value first
    queue_random(230);
    wait_idle();
    write_thresh(10'd0);
    queue_random(230);
    wait_idle();
    write_thresh(10'd1023);
    queue_random(230);
    wait_idle();
    write_thresh(10'($urandom_range(2, 1022)));
    no_idle = 1;
    queue_random(230);
    wait_idle();
    no_idle = 0;
    write_thresh(10'd64);
    queue_random(230);
    wait_idle();

    if (shade_q.size() != 0) report_mismatch("results missing", 0, shade_q.size());
    $display("Sent %0d samples over 5 threshold settings, checked %0d results", beats_in,
             beats_out);
    $display("Sides seen: trans %0d front %0d back %0d graze %0d", side_hits[0], side_hits[1],
             side_hits[2], side_hits[3]);
    if (err_count == 0) begin
      $display("PASS translucent_lobe_shade_core");
    end else begin
      $display("FAIL translucent_lobe_shade_core");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3ms;
    $display("FAIL translucent_lobe_shade_core");
    $finish;
  end

endmodule
